### rtl/luma_box_downscaler_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the luma box downscaler
// Shared implication checks, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef LUMA_BOX_DOWNSCALER_ASSERT_SVH
`define LUMA_BOX_DOWNSCALER_ASSERT_SVH

// same-cycle implication
`define LBD_ASSERT_SAME(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("lbd same-cycle check failed");

// next-cycle implication
`define LBD_ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("lbd next-cycle check failed");

`endif

### rtl/lbd_pkg.sv
// ----------------------------------------------------------------------------
// lbd_pkg
// Types, constants and helpers shared by the luma box downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package lbd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 4096;
    localparam int MAX_RADIUS = 16;

    // BT.709 weights in Q0.16, sum is exactly 65536
    localparam logic [15:0] WEIGHT_R = 16'd13933;
    localparam logic [15:0] WEIGHT_G = 16'd46871;
    localparam logic [15:0] WEIGHT_B = 16'd4732;

    // configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_RADIUS = 2'd2;

    // one in-block pixel handed from front to back
    typedef struct packed {
        logic [7:0]  luma;
        logic        first;
        logic        last;
        logic [9:0]  column;
        logic [11:0] row;
        logic        frame_last;
    } t_pix_entry;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } t_back_state;

    function automatic logic [10:0] clamp_width(input logic [10:0] v);
        logic [10:0] res;
        if (v == 11'd0) res = 11'd1;
        else if (v > 11'(MAX_WIDTH)) res = 11'(MAX_WIDTH);
        else res = v;
        return res;
    endfunction

    function automatic logic [12:0] clamp_height(input logic [12:0] v);
        logic [12:0] res;
        if (v == 13'd0) res = 13'd1;
        else if (v > 13'(MAX_HEIGHT)) res = 13'(MAX_HEIGHT);
        else res = v;
        return res;
    endfunction

    function automatic logic [4:0] clamp_radius(input logic [4:0] v);
        logic [4:0] res;
        if (v == 5'd0) res = 5'd1;
        else if (v > 5'(MAX_RADIUS)) res = 5'(MAX_RADIUS);
        else res = v;
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/lbd_front.sv
// ----------------------------------------------------------------------------
// lbd_front
// Accepts pixels, computes luma, tracks raster position and classifies
// each pixel; in-block pixels are pushed to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_wr_en,
    input  wire  [1:0]           i_cfg_index,
    input  wire  [12:0]          i_cfg_wdata,
    input  wire                  i_valid,
    input  wire  [7:0]           i_red,
    input  wire  [7:0]           i_green,
    input  wire  [7:0]           i_blue,
    input  wire                  i_q_full,
    output logic                 o_ready,
    output logic                 o_push,
    output lbd_pkg::t_pix_entry  o_entry,
    output logic [8:0]           o_area
);

    logic [10:0] r_width;
    logic [12:0] r_height;
    logic [4:0]  r_radius;
    logic [8:0]  r_area;
    logic [9:0]  r_pix_col;
    logic [11:0] r_pix_row;
    logic [3:0]  r_col_in_blk;
    logic [3:0]  r_row_in_blk;
    logic [9:0]  r_blk_col;
    logic [11:0] r_blk_row;
    logic [10:0] r_col_end;   // (blk_col+1)*radius
    logic [12:0] r_row_end;   // (blk_row+1)*radius

    logic [10:0] n_width;
    logic [12:0] n_height;
    logic [4:0]  n_radius;
    logic [8:0]  prod_area;
    logic        accept;
    logic        in_block;
    logic        line_end;
    logic        frame_end;
    logic        col_wrap;
    logic        row_wrap;
    logic        known_reg;
    logic [4:0]  radius_m1;
    logic [23:0] luma_sum;

    // luma: exact weighted sum at full width, truncated
    assign luma_sum = ({8'd0, lbd_pkg::WEIGHT_R} * {16'd0, i_red})
                    + ({8'd0, lbd_pkg::WEIGHT_G} * {16'd0, i_green})
                    + ({8'd0, lbd_pkg::WEIGHT_B} * {16'd0, i_blue});

    // no pixel is taken while a register is written
    assign o_ready   = !i_q_full && !i_cfg_wr_en;
    assign accept    = i_valid && o_ready;
    assign radius_m1 = r_radius - 5'd1;
    assign col_wrap  = ({1'b0, r_col_in_blk} == radius_m1);
    assign row_wrap  = ({1'b0, r_row_in_blk} == radius_m1);
    assign line_end  = (({1'b0, r_pix_col} + 11'd1) == r_width);
    assign frame_end = (({1'b0, r_pix_row} + 13'd1) == r_height);
    assign in_block  = (r_col_end <= r_width) && (r_row_end <= r_height);

    // classification of the current pixel
    always_comb begin
        o_entry.luma       = luma_sum[23:16];
        o_entry.first      = (r_col_in_blk == 4'd0) && (r_row_in_blk == 4'd0);
        o_entry.last       = col_wrap && row_wrap;
        o_entry.column     = r_blk_col;
        o_entry.row        = r_blk_row;
        o_entry.frame_last = (({1'b0, r_col_end} + {7'd0, r_radius}) > {1'b0, r_width})
                          && (({1'b0, r_row_end} + {9'd0, r_radius}) > {1'b0, r_height});
    end

    assign o_push = accept && in_block;
    assign o_area = r_area;

    // clamped configuration values
    always_comb begin
        n_width  = r_width;
        n_height = r_height;
        n_radius = r_radius;
        unique case (i_cfg_index)
            lbd_pkg::REG_WIDTH:  n_width  = lbd_pkg::clamp_width(i_cfg_wdata[10:0]);
            lbd_pkg::REG_HEIGHT: n_height = lbd_pkg::clamp_height(i_cfg_wdata);
            lbd_pkg::REG_RADIUS: n_radius = lbd_pkg::clamp_radius(i_cfg_wdata[4:0]);
            default: ;
        endcase
    end

    assign known_reg = (i_cfg_index == lbd_pkg::REG_WIDTH)
                    || (i_cfg_index == lbd_pkg::REG_HEIGHT)
                    || (i_cfg_index == lbd_pkg::REG_RADIUS);

    // radius squared, up to 256
    assign prod_area = {4'd0, n_radius} * {4'd0, n_radius};

    // configuration and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width      <= 11'(lbd_pkg::MAX_WIDTH);
            r_height     <= 13'd768;
            r_radius     <= 5'd4;
            r_area       <= 9'd16;
            r_pix_col    <= '0;
            r_pix_row    <= '0;
            r_col_in_blk <= '0;
            r_row_in_blk <= '0;
            r_blk_col    <= '0;
            r_blk_row    <= '0;
            r_col_end    <= 11'd4;
            r_row_end    <= 13'd4;
        end else if (i_cfg_wr_en) begin
            // known register: store and restart the frame
            if (known_reg) begin
                r_width      <= n_width;
                r_height     <= n_height;
                r_radius     <= n_radius;
                r_area       <= prod_area;
                r_pix_col    <= '0;
                r_pix_row    <= '0;
                r_col_in_blk <= '0;
                r_row_in_blk <= '0;
                r_blk_col    <= '0;
                r_blk_row    <= '0;
                r_col_end    <= {6'd0, n_radius};
                r_row_end    <= {8'd0, n_radius};
            end
        end else if (accept) begin
            if (line_end) begin
                r_pix_col    <= '0;
                r_col_in_blk <= '0;
                r_blk_col    <= '0;
                r_col_end    <= {6'd0, r_radius};
                if (frame_end) begin
                    r_pix_row    <= '0;
                    r_row_in_blk <= '0;
                    r_blk_row    <= '0;
                    r_row_end    <= {8'd0, r_radius};
                end else begin
                    r_pix_row <= r_pix_row + 12'd1;
                    if (row_wrap) begin
                        r_row_in_blk <= '0;
                        r_blk_row    <= r_blk_row + 12'd1;
                        r_row_end    <= r_row_end + {8'd0, r_radius};
                    end else begin
                        r_row_in_blk <= r_row_in_blk + 4'd1;
                    end
                end
            end else begin
                r_pix_col <= r_pix_col + 10'd1;
                if (col_wrap) begin
                    r_col_in_blk <= '0;
                    r_blk_col    <= r_blk_col + 10'd1;
                    r_col_end    <= r_col_end + {6'd0, r_radius};
                end else begin
                    r_col_in_blk <= r_col_in_blk + 4'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

### rtl/lbd_queue.sv
// ----------------------------------------------------------------------------
// lbd_queue
// Two-entry FIFO between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  lbd_pkg::t_pix_entry  i_entry,
    input  wire                  i_pop,
    output lbd_pkg::t_pix_entry  o_head,
    output logic                 o_full,
    output logic                 o_empty
);

    lbd_pkg::t_pix_entry r_slot [2];
    logic                r_wr_ptr;
    logic                r_rd_ptr;
    logic [1:0]          r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    // storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_entry;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            if (i_push && !i_pop)      r_count <= r_count + 2'd1;
            else if (!i_push && i_pop) r_count <= r_count - 2'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/lbd_back.sv
// ----------------------------------------------------------------------------
// lbd_back
// Column accumulators in a RAM, read-modify-write per pixel, then a
// bit-serial divide by radius squared for each finished block.
// ----------------------------------------------------------------------------
`default_nettype none

module lbd_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_q_empty,
    input  lbd_pkg::t_pix_entry  i_head,
    input  wire  [8:0]           i_area,
    output logic                 o_pop,
    input  wire                  i_ready,
    output logic                 o_valid,
    output logic [7:0]           o_block_value,
    output logic [9:0]           o_block_column,
    output logic [11:0]          o_block_row,
    output logic                 o_frame_last
);

    lbd_pkg::t_back_state r_state;
    lbd_pkg::t_back_state n_state;

    logic [15:0]         r_sums [lbd_pkg::MAX_WIDTH];
    logic [15:0]         r_rd_data;
    lbd_pkg::t_pix_entry r_entry;
    logic [15:0]         r_quo;
    logic [8:0]          r_rem;
    logic [3:0]          r_cnt;

    logic [15:0] acc_sum;
    logic        wr_en;
    logic [9:0]  trial;
    logic [9:0]  diff;
    logic        q_bit;

    // accumulate
    assign acc_sum = r_entry.first ? {8'd0, r_entry.luma}
                                   : r_rd_data + {8'd0, r_entry.luma};

    // one restoring step
    assign trial = {r_rem, r_quo[15]};
    assign diff  = trial - {1'b0, i_area};
    assign q_bit = (trial >= {1'b0, i_area});

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbd_pkg::ST_IDLE: if (!i_q_empty) n_state = lbd_pkg::ST_ACC;
            lbd_pkg::ST_ACC:  n_state = r_entry.last ? lbd_pkg::ST_DIV : lbd_pkg::ST_IDLE;
            lbd_pkg::ST_DIV:  if (r_cnt == 4'd15) n_state = lbd_pkg::ST_OUT;
            lbd_pkg::ST_OUT:  if (i_ready) n_state = lbd_pkg::ST_IDLE;
            default:          n_state = lbd_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop   = 1'b0;
        wr_en   = 1'b0;
        o_valid = 1'b0;
        unique case (r_state)
            lbd_pkg::ST_IDLE: o_pop   = !i_q_empty;
            lbd_pkg::ST_ACC:  wr_en   = 1'b1;
            lbd_pkg::ST_DIV:  ;
            lbd_pkg::ST_OUT:  o_valid = 1'b1;
            default:          ;
        endcase
    end

    assign o_block_value  = r_quo[7:0];
    assign o_block_column = r_entry.column;
    assign o_block_row    = r_entry.row;
    assign o_frame_last   = r_entry.frame_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= lbd_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // accumulator RAM, registered read
    always_ff @(posedge i_clk) begin
        if (wr_en) r_sums[r_entry.column] <= acc_sum;
        if (o_pop) r_rd_data <= r_sums[i_head.column];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (o_pop) r_entry <= i_head;
        if (r_state == lbd_pkg::ST_ACC) begin
            r_quo <= acc_sum;
            r_rem <= '0;
            r_cnt <= '0;
        end else if (r_state == lbd_pkg::ST_DIV) begin
            r_quo <= {r_quo[14:0], q_bit};
            r_rem <= q_bit ? diff[8:0] : trial[8:0];
            r_cnt <= r_cnt + 4'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/luma_box_downscaler.sv
// Result path: a pixel that completes a block passes through the queue, the RAM
// read, the accumulate step and the 16-step divide, then waits out any output stall.
// Flow: the back end handles one queued pixel at a time, an accumulator RAM read and
// then its write back; a block-completing pixel also holds it in the divider and output.
// Reset: synchronous, active low; registers return to 1024 x 768, radius 4,
// frame position to zero; accumulator RAM is not cleared.
// ----------------------------------------------------------------------------
// luma_box_downscaler
// RGB to BT.709 luma, averaged over square blocks wholly inside the frame, one result per block.
// ----------------------------------------------------------------------------
`default_nettype none

module luma_box_downscaler (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_cfg_wr_en,
    input  wire  [1:0]  i_cfg_index,
    input  wire  [12:0] i_cfg_wdata,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [7:0]  i_red,
    input  wire  [7:0]  i_green,
    input  wire  [7:0]  i_blue,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [7:0]  o_block_value,
    output logic [9:0]  o_block_column,
    output logic [11:0] o_block_row,
    output logic        o_frame_last
);

    lbd_pkg::t_pix_entry push_entry;
    lbd_pkg::t_pix_entry head_entry;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic [8:0]          area;

    lbd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_red       (i_red),
        .i_green     (i_green),
        .i_blue      (i_blue),
        .i_q_full    (q_full),
        .o_ready     (o_ready),
        .o_push      (q_push),
        .o_entry     (push_entry),
        .o_area      (area)
    );

    lbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (push_entry),
        .i_pop   (q_pop),
        .o_head  (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lbd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_head         (head_entry),
        .i_area         (area),
        .o_pop          (q_pop),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_block_value  (o_block_value),
        .o_block_column (o_block_column),
        .o_block_row    (o_block_row),
        .o_frame_last   (o_frame_last)
    );

    `include "luma_box_downscaler_assert.svh"

    // the queue never overflows or underflows
    `LBD_ASSERT_SAME(a_no_push_full, i_clk, i_rst_n, q_push, !q_full)
    `LBD_ASSERT_SAME(a_no_pop_empty, i_clk, i_rst_n, q_pop, !q_empty)
    // o_valid drops after a delivered result, so results never come back to back
    `LBD_ASSERT_NEXT(a_out_gap, i_clk, i_rst_n, o_valid && i_ready, !o_valid)

endmodule

`default_nettype wire
